>>> hw/rtl/lsw_pkg.sv
// ----------------------------------------------------------------------------
// lsw_pkg
// Shared types, codes and helpers of the latency sample window.
// ----------------------------------------------------------------------------
package lsw_pkg;

   localparam int CAPACITY_DEF = 32;

   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_SELECT = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   localparam logic [2:0] ST_ADDED    = 3'd0;
   localparam logic [2:0] ST_DUP      = 3'd1;
   localparam logic [2:0] ST_MISMATCH = 3'd2;
   localparam logic [2:0] ST_CLEARED  = 3'd3;
   localparam logic [2:0] ST_EMPTY    = 3'd4;
   localparam logic [2:0] ST_COUNT    = 3'd5;
   localparam logic [2:0] ST_TIME     = 3'd6;
   localparam logic [2:0] ST_TUMBLE   = 3'd7;

   localparam logic [1:0] KIND_COUNT  = 2'd0;
   localparam logic [1:0] KIND_TIME   = 2'd1;
   localparam logic [1:0] KIND_TUMBLE = 2'd2;

   localparam logic [2:0] REG_WINDOW_KIND     = 3'd0;
   localparam logic [2:0] REG_KEEP_COUNT      = 3'd1;
   localparam logic [2:0] REG_WINDOW_DURATION = 3'd2;
   localparam logic [2:0] REG_WINDOW_CAPACITY = 3'd3;
   localparam logic [2:0] REG_BUCKET_ANCHOR   = 3'd4;
   localparam logic [2:0] REG_MAX_SPAN        = 3'd5;

   typedef enum logic [1:0] {
      SCAN_DUP,
      SCAN_MAX,
      SCAN_COUNT,
      SCAN_FIND
   } scan_kind_type;

   typedef struct packed {
      logic [63:0] tag;
      logic [63:0] ticks;
      logic [63:0] seq;
      logic [63:0] lat;
   } entry_type;

   typedef struct packed {
      logic          latch_in;
      logic          latch_id;
      logic          clear_win;
      logic          bump_mis;
      logic          bump_dup;
      logic          insert;
      logic          trim;
      logic          scan_start;
      scan_kind_type scan_kind;
      logic          scan_step;
      logic          div_start;
      logic          advance;
      logic          send;
      logic [2:0]    send_status;
      logic          send_sel;
      logic          send_pick;
   } dp_cmd_type;

   typedef struct packed {
      logic       id_valid;
      logic       id_mismatch;
      logic       held_zero;
      logic       scan_done;
      logic       dup_found;
      logic       over_cap;
      logic       need_div;
      logic       div_done;
      logic       kept_zero;
      logic       pick_ok;
      logic       pick_last;
      logic [2:0] sel_status;
   } dp_sts_type;

   // order by signed ticks, then sequence, then id
   function automatic logic key_less(entry_type a, entry_type b);
      logic r;
      if (a.ticks != b.ticks) begin
         r = $signed(a.ticks) < $signed(b.ticks);
      end else if (a.seq != b.seq) begin
         r = a.seq < b.seq;
      end else begin
         r = a.tag < b.tag;
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/lsw_div.sv
// ----------------------------------------------------------------------------
// lsw_div
// Restoring radix-2 remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsw_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [62:0] divisor,
   output logic        busy,
   output logic [63:0] remainder
);

   logic [63:0] rem_ff;
   logic [63:0] quo_ff;
   logic [62:0] div_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic [63:0] shifted;
   logic [63:0] rem_in;

   always_comb begin
      shifted = {rem_ff[62:0], quo_ff[63]};
      if (shifted >= {1'b0, div_ff}) begin
         rem_in = shifted - {1'b0, div_ff};
      end else begin
         rem_in = shifted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[62:0], 1'b0};
      end
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

>>> hw/rtl/lsw_datapath.sv
// ----------------------------------------------------------------------------
// lsw_datapath
// Sample store, configuration, counters, scan engine and result register.
// ----------------------------------------------------------------------------
module lsw_datapath
   import lsw_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_sts_type  sts,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data,
   input  logic [63:0] req_sample_tag,
   input  logic [63:0] req_series_tag,
   input  logic [63:0] req_generation_tag,
   input  logic [63:0] req_observed_ticks,
   input  logic [63:0] req_sequence_number,
   input  logic [63:0] req_latency_value,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_picked_tag,
   output logic [63:0] rsp_picked_ticks,
   output logic [63:0] rsp_picked_latency,
   output logic [6:0]  rsp_retained_count,
   output logic [6:0]  rsp_excluded_count,
   output logic        rsp_last_item,
   output logic [31:0] rsp_evicted_total,
   output logic [31:0] rsp_out_of_order_total,
   output logic [31:0] rsp_mismatch_total,
   output logic [31:0] rsp_duplicate_total
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW:0]   CAP_EXT  = (CW + 1)'(CAPACITY);
   localparam logic [6:0]    CAP7     = 7'(CAPACITY);
   localparam logic [AW-1:0] HEAD_TOP = AW'(CAPACITY - 1);

   // configuration
   logic [1:0]  kind_ff;
   logic [6:0]  keep_ff;
   logic [62:0] dur_ff;
   logic [6:0]  cap_ff;
   logic [63:0] anchor_ff;
   logic [62:0] span_ff;

   // latched request
   entry_type   in_ff;
   logic [63:0] in_series_ff;
   logic [63:0] in_gen_ff;

   // window state
   entry_type   mem [CAPACITY];
   entry_type   rd_ff;
   logic [AW-1:0] head_ff;
   logic [CW-1:0] held_ff;
   logic [63:0] id_series_ff;
   logic [63:0] id_gen_ff;
   logic        id_valid_ff;
   logic        newest_valid_ff;
   logic [63:0] newest_seen_ff;
   logic [31:0] evict_ff;
   logic [31:0] late_ff;
   logic [31:0] mis_ff;
   logic [31:0] dup_cnt_ff;

   // scan engine
   scan_kind_type scan_kind_ff;
   logic [CW-1:0] iss_ff;
   logic          vld_ff;
   logic          dup_ff;
   logic          best_vld_ff;
   entry_type     best_ff;
   entry_type     prev_ff;
   logic          have_prev_ff;
   logic [63:0]   sel_newest_ff;
   logic [CW-1:0] rank_ff;
   logic [CW-1:0] emitted_ff;
   logic [CW-1:0] kept_cnt_ff;
   logic [63:0]   bucket_lo_ff;
   logic [63:0]   bucket_hi_ff;

   // result register
   logic        rsp_strobe_ff;
   logic [2:0]  rsp_status_ff;
   logic [63:0] rsp_tag_ff;
   logic [63:0] rsp_ticks_ff;
   logic [63:0] rsp_lat_ff;
   logic [6:0]  rsp_ret_ff;
   logic [6:0]  rsp_exc_ff;
   logic        rsp_last_ff;

   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] head_in;
   logic          issue;
   logic          full;
   logic [62:0]   dur_eff;
   logic [6:0]    cap_eff;
   logic [63:0]   boff;
   logic          known;
   logic [2:0]    sel_status;
   logic [6:0]    held7;
   logic [6:0]    kept7;
   logic [6:0]    first7;
   logic          pick_ok;
   logic          pick_last;
   logic          div_busy;
   logic [63:0]   div_rem;
   logic          late;

   function automatic logic [AW-1:0] slot_of(logic [AW-1:0] h, logic [CW-1:0] i);
      logic [CW:0] s;
      s = (CW + 1)'(h) + {1'b0, i};
      if (s >= CAP_EXT) begin
         s = s - CAP_EXT;
      end
      return s[AW-1:0];
   endfunction

   function automatic logic [31:0] sat_inc(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   // time or tumbling rule for one sample time
   function automatic logic keep_ticks(logic [63:0] t);
      logic [63:0] off;
      logic        time_ok;
      logic        tumb_ok;
      time_ok = !($signed(sel_newest_ff) < $signed(t))
                && ((sel_newest_ff - t) <= {1'b0, dur_eff});
      off     = t - anchor_ff;
      tumb_ok = !($signed(t) < $signed(anchor_ff)) && (off <= {1'b0, span_ff})
                && (off >= bucket_lo_ff) && (off < bucket_hi_ff);
      return ((sel_status == ST_TIME) || !known) ? time_ok : tumb_ok;
   endfunction

   always_comb begin
      rd_addr  = slot_of(head_ff, iss_ff);
      wr_addr  = slot_of(head_ff, held_ff);
      head_in  = (head_ff == HEAD_TOP) ? '0 : head_ff + 1'b1;
      issue    = cmd.scan_step && (iss_ff != held_ff);
      full     = (held_ff == CW'(CAPACITY));
      dur_eff  = (dur_ff == '0) ? 63'd1 : dur_ff;
      cap_eff  = (cap_ff == '0) ? 7'd1 : ((cap_ff > CAP7) ? CAP7 : cap_ff);
      boff     = sel_newest_ff - anchor_ff;
      known    = !($signed(sel_newest_ff) < $signed(anchor_ff)) && (boff <= {1'b0, span_ff});
      case (kind_ff)
         KIND_TIME:   sel_status = ST_TIME;
         KIND_TUMBLE: sel_status = ST_TUMBLE;
         default:     sel_status = ST_COUNT;
      endcase
      held7    = 7'(held_ff);
      if (sel_status == ST_COUNT) begin
         kept7 = (held7 <= keep_ff) ? held7 : keep_ff;
      end else begin
         kept7 = 7'(kept_cnt_ff);
      end
      first7   = (held7 > keep_ff) ? held7 - keep_ff : 7'd0;
      pick_ok  = (sel_status == ST_COUNT) ? (7'(rank_ff) >= first7) : keep_ticks(best_ff.ticks);
      pick_last = ((7'(emitted_ff) + 7'd1) == kept7);
      late     = newest_valid_ff && ($signed(in_ff.ticks) < $signed(newest_seen_ff));
   end

   always_comb begin
      sts.id_valid    = id_valid_ff;
      sts.id_mismatch = (id_series_ff != in_series_ff) || (id_gen_ff != in_gen_ff);
      sts.held_zero   = (held_ff == '0);
      sts.scan_done   = (iss_ff == held_ff) && !vld_ff;
      sts.dup_found   = dup_ff;
      sts.over_cap    = held7 > cap_eff;
      sts.need_div    = (sel_status == ST_TUMBLE) && known;
      sts.div_done    = !div_busy;
      sts.kept_zero   = (kept7 == 7'd0);
      sts.pick_ok     = pick_ok;
      sts.pick_last   = pick_last;
      sts.sel_status  = sel_status;
   end

   lsw_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (boff),
      .divisor   (dur_eff),
      .busy      (div_busy),
      .remainder (div_rem)
   );

   // sample store
   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         mem[wr_addr] <= in_ff;
      end
      rd_ff <= mem[rd_addr];
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= 2'd0;
         keep_ff   <= 7'd1;
         dur_ff    <= 63'd1000000;
         cap_ff    <= 7'd32;
         anchor_ff <= '0;
         span_ff   <= 63'd1099511627776;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_WINDOW_KIND:     kind_ff   <= csr_write_data[1:0];
            REG_KEEP_COUNT:      keep_ff   <= csr_write_data[6:0];
            REG_WINDOW_DURATION: dur_ff    <= csr_write_data[62:0];
            REG_WINDOW_CAPACITY: cap_ff    <= csr_write_data[6:0];
            REG_BUCKET_ANCHOR:   anchor_ff <= csr_write_data;
            REG_MAX_SPAN:        span_ff   <= csr_write_data[62:0];
            default: ;
         endcase
      end
   end

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.latch_in) begin
         in_ff.tag    <= req_sample_tag;
         in_ff.ticks  <= req_observed_ticks;
         in_ff.seq    <= req_sequence_number;
         in_ff.lat    <= req_latency_value;
         in_series_ff <= req_series_tag;
         in_gen_ff    <= req_generation_tag;
      end
   end

   // window control state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff         <= '0;
         held_ff         <= '0;
         id_series_ff    <= '0;
         id_gen_ff       <= '0;
         id_valid_ff     <= 1'b0;
         newest_valid_ff <= 1'b0;
         newest_seen_ff  <= '0;
         evict_ff        <= '0;
         late_ff         <= '0;
         mis_ff          <= '0;
         dup_cnt_ff      <= '0;
      end else begin
         if (cmd.clear_win) begin
            head_ff         <= '0;
            held_ff         <= '0;
            id_series_ff    <= '0;
            id_gen_ff       <= '0;
            id_valid_ff     <= 1'b0;
            newest_valid_ff <= 1'b0;
            newest_seen_ff  <= '0;
         end
         if (cmd.latch_id) begin
            id_series_ff <= in_series_ff;
            id_gen_ff    <= in_gen_ff;
            id_valid_ff  <= 1'b1;
         end
         if (cmd.bump_mis) begin
            mis_ff <= sat_inc(mis_ff);
         end
         if (cmd.bump_dup) begin
            dup_cnt_ff <= sat_inc(dup_cnt_ff);
         end
         if (cmd.insert) begin
            if (late) begin
               late_ff <= sat_inc(late_ff);
            end else begin
               newest_seen_ff  <= in_ff.ticks;
               newest_valid_ff <= 1'b1;
            end
            // a full window overwrites its oldest entry
            if (full) begin
               head_ff  <= head_in;
               evict_ff <= sat_inc(evict_ff);
            end else begin
               held_ff <= held_ff + 1'b1;
            end
         end
         if (cmd.trim) begin
            head_ff  <= head_in;
            held_ff  <= held_ff - 1'b1;
            evict_ff <= sat_inc(evict_ff);
         end
      end
   end

   // scan engine control
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff       <= '0;
         vld_ff       <= 1'b0;
         scan_kind_ff <= SCAN_DUP;
      end else if (cmd.scan_start) begin
         iss_ff       <= '0;
         vld_ff       <= 1'b0;
         scan_kind_ff <= cmd.scan_kind;
      end else begin
         vld_ff <= issue;
         if (issue) begin
            iss_ff <= iss_ff + 1'b1;
         end
      end
   end

   // scan accumulators
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         dup_ff      <= 1'b0;
         best_vld_ff <= 1'b0;
         if (cmd.scan_kind == SCAN_MAX) begin
            rank_ff      <= '0;
            emitted_ff   <= '0;
            have_prev_ff <= 1'b0;
         end
         if (cmd.scan_kind == SCAN_COUNT) begin
            kept_cnt_ff  <= '0;
            bucket_lo_ff <= boff - div_rem;
            bucket_hi_ff <= boff - div_rem + {1'b0, dur_eff};
         end
      end else if (vld_ff) begin
         case (scan_kind_ff)
            SCAN_DUP: begin
               if (rd_ff.tag == in_ff.tag) begin
                  dup_ff <= 1'b1;
               end
            end
            SCAN_MAX: begin
               if (!best_vld_ff || ($signed(rd_ff.ticks) > $signed(sel_newest_ff))) begin
                  sel_newest_ff <= rd_ff.ticks;
                  best_vld_ff   <= 1'b1;
               end
            end
            SCAN_COUNT: begin
               if (keep_ticks(rd_ff.ticks)) begin
                  kept_cnt_ff <= kept_cnt_ff + 1'b1;
               end
            end
            SCAN_FIND: begin
               if ((!have_prev_ff || key_less(prev_ff, rd_ff))
                   && (!best_vld_ff || key_less(rd_ff, best_ff))) begin
                  best_ff     <= rd_ff;
                  best_vld_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
      if (cmd.advance) begin
         prev_ff      <= best_ff;
         have_prev_ff <= 1'b1;
         rank_ff      <= rank_ff + 1'b1;
         if (pick_ok) begin
            emitted_ff <= emitted_ff + 1'b1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.send;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.send) begin
         rsp_status_ff <= cmd.send_status;
         rsp_tag_ff    <= cmd.send_pick ? best_ff.tag : '0;
         rsp_ticks_ff  <= cmd.send_pick ? best_ff.ticks : '0;
         rsp_lat_ff    <= cmd.send_pick ? best_ff.lat : '0;
         rsp_ret_ff    <= held7;
         rsp_exc_ff    <= cmd.send_sel ? held7 - kept7 : 7'd0;
         rsp_last_ff   <= cmd.send_pick ? pick_last : 1'b1;
      end
   end

   assign rsp_strobe             = rsp_strobe_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_picked_tag         = rsp_tag_ff;
   assign rsp_picked_ticks       = rsp_ticks_ff;
   assign rsp_picked_latency     = rsp_lat_ff;
   assign rsp_retained_count     = rsp_ret_ff;
   assign rsp_excluded_count     = rsp_exc_ff;
   assign rsp_last_item          = rsp_last_ff;
   assign rsp_evicted_total      = evict_ff;
   assign rsp_out_of_order_total = late_ff;
   assign rsp_mismatch_total     = mis_ff;
   assign rsp_duplicate_total    = dup_cnt_ff;

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held7 <= CAP7)
      else $error("held count beyond capacity");

   a_pick_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.send && cmd.send_pick) |-> (7'(emitted_ff) < kept7))
      else $error("more picks than kept samples");

   a_insert_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> (!vld_ff && !cmd.scan_step))
      else $error("insert during a scan");

endmodule

>>> hw/rtl/lsw_ctrl.sv
// ----------------------------------------------------------------------------
// lsw_ctrl
// Sequencer for add, clear and select operations.
// ----------------------------------------------------------------------------
module lsw_ctrl
   import lsw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_mode,
   input  dp_sts_type sts,
   output dp_cmd_type cmd,
   output logic       busy
);

   typedef enum logic [3:0] {
      IDLE,
      ADD_CHK,
      ADD_DUP,
      ADD_INS,
      ADD_TRIM,
      CLEAR,
      SEL_BEGIN,
      SEL_MAX,
      SEL_DIV,
      SEL_COUNT,
      SEL_FIND,
      SEL_EMIT,
      SEND
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] status_ff, status_in;
   logic       sel_ff, sel_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      status_in = status_ff;
      sel_in    = sel_ff;
      case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.latch_in = 1'b1;
               case (req_mode)
                  MODE_ADD:    state_in = ADD_CHK;
                  MODE_SELECT: state_in = SEL_BEGIN;
                  MODE_CLEAR:  state_in = CLEAR;
                  default:     state_in = IDLE;
               endcase
            end
         end
         ADD_CHK: begin
            if (sts.id_valid && sts.id_mismatch) begin
               cmd.bump_mis = 1'b1;
               status_in    = ST_MISMATCH;
               sel_in       = 1'b0;
               state_in     = SEND;
            end else begin
               cmd.latch_id   = !sts.id_valid;
               cmd.scan_start = 1'b1;
               cmd.scan_kind  = SCAN_DUP;
               state_in       = ADD_DUP;
            end
         end
         ADD_DUP: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               if (sts.dup_found) begin
                  cmd.bump_dup = 1'b1;
                  status_in    = ST_DUP;
                  sel_in       = 1'b0;
                  state_in     = SEND;
               end else begin
                  state_in = ADD_INS;
               end
            end
         end
         ADD_INS: begin
            cmd.insert = 1'b1;
            state_in   = ADD_TRIM;
         end
         ADD_TRIM: begin
            if (sts.over_cap) begin
               cmd.trim = 1'b1;
            end else begin
               status_in = ST_ADDED;
               sel_in    = 1'b0;
               state_in  = SEND;
            end
         end
         CLEAR: begin
            cmd.clear_win = 1'b1;
            status_in     = ST_CLEARED;
            sel_in        = 1'b0;
            state_in      = SEND;
         end
         SEL_BEGIN: begin
            if (sts.held_zero) begin
               status_in = ST_EMPTY;
               sel_in    = 1'b0;
               state_in  = SEND;
            end else begin
               cmd.scan_start = 1'b1;
               cmd.scan_kind  = SCAN_MAX;
               state_in       = SEL_MAX;
            end
         end
         SEL_MAX: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               if (sts.need_div) begin
                  cmd.div_start = 1'b1;
                  state_in      = SEL_DIV;
               end else begin
                  cmd.scan_start = 1'b1;
                  cmd.scan_kind  = SCAN_COUNT;
                  state_in       = SEL_COUNT;
               end
            end
         end
         SEL_DIV: begin
            if (sts.div_done) begin
               cmd.scan_start = 1'b1;
               cmd.scan_kind  = SCAN_COUNT;
               state_in       = SEL_COUNT;
            end
         end
         SEL_COUNT: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               if (sts.kept_zero) begin
                  status_in = sts.sel_status;
                  sel_in    = 1'b1;
                  state_in  = SEND;
               end else begin
                  cmd.scan_start = 1'b1;
                  cmd.scan_kind  = SCAN_FIND;
                  state_in       = SEL_FIND;
               end
            end
         end
         SEL_FIND: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = SEL_EMIT;
            end
         end
         SEL_EMIT: begin
            cmd.advance = 1'b1;
            if (sts.pick_ok) begin
               cmd.send        = 1'b1;
               cmd.send_status = sts.sel_status;
               cmd.send_sel    = 1'b1;
               cmd.send_pick   = 1'b1;
            end
            if (sts.pick_ok && sts.pick_last) begin
               state_in = IDLE;
            end else begin
               cmd.scan_start = 1'b1;
               cmd.scan_kind  = SCAN_FIND;
               state_in       = SEL_FIND;
            end
         end
         SEND: begin
            cmd.send        = 1'b1;
            cmd.send_status = status_ff;
            cmd.send_sel    = sel_ff;
            state_in        = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         status_ff <= ST_ADDED;
         sel_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         sel_ff    <= sel_in;
      end
   end

   assign busy = (state_ff != IDLE);

endmodule

>>> hw/rtl/latency_sample_window_core.sv
// ----------------------------------------------------------------------------
// latency_sample_window_core
// Bounded window of latency samples with duplicate, identity and order checks
// and a sorted count, time or tumbling-bucket select.
//
//   port group   direction   handshake
//   req_*        in          beat taken when start is high and busy is low
//   rsp_*        out         one beat per cycle with rsp_strobe high
//   csr_*        in          write taken when csr_write_enable is high
//
// add: one store scan, skipped on an identity mismatch, plus a trim step
//   per eviction down to a lowered capacity; clear: a clear step, a send step
// select: a newest-time scan, the bucket remainder division in tumbling mode,
//   a count scan, then a find scan per rank visited; every rank up to the
//   last kept sample costs a full scan; a beat follows its command next cycle
// synchronous reset, no clearing pass; rsp_* is never held off
// ----------------------------------------------------------------------------
module latency_sample_window_core
   import lsw_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [63:0] req_sample_tag,
   input  logic [63:0] req_series_tag,
   input  logic [63:0] req_generation_tag,
   input  logic [63:0] req_observed_ticks,
   input  logic [63:0] req_sequence_number,
   input  logic [63:0] req_latency_value,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_picked_tag,
   output logic [63:0] rsp_picked_ticks,
   output logic [63:0] rsp_picked_latency,
   output logic [6:0]  rsp_retained_count,
   output logic [6:0]  rsp_excluded_count,
   output logic        rsp_last_item,
   output logic [31:0] rsp_evicted_total,
   output logic [31:0] rsp_out_of_order_total,
   output logic [31:0] rsp_mismatch_total,
   output logic [31:0] rsp_duplicate_total,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   lsw_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   lsw_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data),
      .req_sample_tag         (req_sample_tag),
      .req_series_tag         (req_series_tag),
      .req_generation_tag     (req_generation_tag),
      .req_observed_ticks     (req_observed_ticks),
      .req_sequence_number    (req_sequence_number),
      .req_latency_value      (req_latency_value),
      .rsp_strobe             (rsp_strobe),
      .rsp_status             (rsp_status),
      .rsp_picked_tag         (rsp_picked_tag),
      .rsp_picked_ticks       (rsp_picked_ticks),
      .rsp_picked_latency     (rsp_picked_latency),
      .rsp_retained_count     (rsp_retained_count),
      .rsp_excluded_count     (rsp_excluded_count),
      .rsp_last_item          (rsp_last_item),
      .rsp_evicted_total      (rsp_evicted_total),
      .rsp_out_of_order_total (rsp_out_of_order_total),
      .rsp_mismatch_total     (rsp_mismatch_total),
      .rsp_duplicate_total    (rsp_duplicate_total)
   );

endmodule
